>>> hdl/dip_pkg.sv
// shared constants and types for the decimal token parser with duplicate check
package dip_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STORED_W = 10;
    localparam int PROD_W   = VALUE_W + 4;

    localparam logic [VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SYNTAX   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

>>> hdl/dip_in_if.sv
// input channel: command and character beats
interface dip_in_if import dip_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output command, output char_code, input ready);
    modport sink   (input valid, input command, input char_code, output ready);
endinterface

>>> hdl/dip_out_if.sv
// output channel: one report beat per token
interface dip_out_if import dip_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  parsed_value;
    logic [STORED_W-1:0]        stored_count;

    modport source (output valid, output status, output parsed_value, output stored_count,
                    input ready);
    modport sink   (input valid, input status, input parsed_value, input stored_count,
                    output ready);
endinterface

>>> hdl/decimal_int_parse_dedup_top.sv
// top level: decimal token parser with a duplicate-checked value table
//
// Tokens arrive one beat per character on the token channel; an end beat closes
// the token and yields one report beat with status, value and table fill. A clear
// beat or a character beat is handled in S_IDLE. An end beat that fails on syntax,
// range or an earlier sticky error goes straight to S_DONE. Otherwise the
// accepted-value table, a single-port-read memory with a registered read
// output, is scanned one entry per cycle in S_SCAN, stopping early on a duplicate
// hit. The report sits in an output register, so new character beats are taken
// while it waits. The table needs no clearing pass: only entries below the fill
// count are ever read.
module decimal_int_parse_dedup_top import dip_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    dip_in_if.sink    token,
    dip_out_if.source report
);

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic                 at_start_reg, at_start_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic                 syntax_bad_reg, syntax_bad_next;
    logic                 range_ovf_reg, range_ovf_next;
    logic                 sticky_reg, sticky_next;
    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;

    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic [STORED_W-1:0]  out_count_reg, out_count_next;

    logic [VALUE_W-1:0]   mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]   mem_q_reg;
    logic                 mem_we;
    logic                 mem_re;

    logic [CHAR_W-1:0]    digit_byte;
    logic [PROD_W-1:0]    prod;
    logic                 issue;

    assign digit_byte = token.char_code - CHAR_ZERO;
    assign prod = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                + {{(PROD_W-4){1'b0}}, digit_byte[3:0]};
    assign issue = (rd_idx_reg < entry_count_reg);

    assign token.ready         = (state_reg == S_IDLE);
    assign report.valid        = out_valid_reg;
    assign report.status       = out_status_reg;
    assign report.parsed_value = $signed(out_value_reg);
    assign report.stored_count = out_count_reg;

    // table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[entry_count_reg[ADDR_W-1:0]] <= value_reg;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mag_reg         <= '0;
            neg_reg         <= 1'b0;
            at_start_reg    <= 1'b1;
            digit_seen_reg  <= 1'b0;
            syntax_bad_reg  <= 1'b0;
            range_ovf_reg   <= 1'b0;
            sticky_reg      <= 1'b0;
            entry_count_reg <= '0;
            rd_idx_reg      <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mag_reg         <= mag_next;
            neg_reg         <= neg_next;
            at_start_reg    <= at_start_next;
            digit_seen_reg  <= digit_seen_next;
            syntax_bad_reg  <= syntax_bad_next;
            range_ovf_reg   <= range_ovf_next;
            sticky_reg      <= sticky_next;
            entry_count_reg <= entry_count_next;
            rd_idx_reg      <= rd_idx_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        at_start_next    = at_start_reg;
        digit_seen_next  = digit_seen_reg;
        syntax_bad_next  = syntax_bad_reg;
        range_ovf_next   = range_ovf_reg;
        sticky_next      = sticky_reg;
        entry_count_next = entry_count_reg;
        rd_idx_next      = rd_idx_reg;
        pend_next        = 1'b0;
        out_valid_next   = out_valid_reg;
        value_next       = value_reg;
        status_next      = status_reg;
        out_status_next  = out_status_reg;
        out_value_next   = out_value_reg;
        out_count_next   = out_count_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        if (out_valid_reg && report.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (token.valid)
                begin
                    unique case (token.command)
                        CMD_CLEAR:
                        begin
                            mag_next         = '0;
                            neg_next         = 1'b0;
                            at_start_next    = 1'b1;
                            digit_seen_next  = 1'b0;
                            syntax_bad_next  = 1'b0;
                            range_ovf_next   = 1'b0;
                            sticky_next      = 1'b0;
                            entry_count_next = '0;
                        end
                        CMD_CHAR:
                        begin
                            if (at_start_reg && (token.char_code == CHAR_PLUS
                                              || token.char_code == CHAR_MINUS))
                            begin
                                neg_next = (token.char_code == CHAR_MINUS);
                            end
                            else if (token.char_code >= CHAR_ZERO
                                  && token.char_code <= CHAR_NINE)
                            begin
                                digit_seen_next = 1'b1;
                                if (prod > {4'b0, MAG_LIMIT})
                                begin
                                    range_ovf_next = 1'b1;
                                    mag_next       = MAG_LIMIT;
                                end
                                else
                                begin
                                    mag_next = prod[VALUE_W-1:0];
                                end
                            end
                            else
                            begin
                                syntax_bad_next = 1'b1;
                            end
                            at_start_next = 1'b0;
                        end
                        CMD_END:
                        begin
                            value_next      = neg_reg ? (VALUE_W'(0) - mag_reg) : mag_reg;
                            mag_next        = '0;
                            neg_next        = 1'b0;
                            at_start_next   = 1'b1;
                            digit_seen_next = 1'b0;
                            syntax_bad_next = 1'b0;
                            range_ovf_next  = 1'b0;
                            if (sticky_reg)
                            begin
                                status_next = STAT_REJECTED;
                                state_next  = S_DONE;
                            end
                            else if (syntax_bad_reg || !digit_seen_reg)
                            begin
                                status_next = STAT_SYNTAX;
                                state_next  = S_DONE;
                            end
                            else if (range_ovf_reg || (!neg_reg && mag_reg == MAG_LIMIT))
                            begin
                                status_next = STAT_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (pend_reg && mem_q_reg == value_reg)
                begin
                    status_next = STAT_DUP;
                    state_next  = S_DONE;
                end
                else if (!issue)
                begin
                    if (entry_count_reg >= CNT_W'(TABLE_DEPTH))
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        status_next      = STAT_OK;
                        mem_we           = 1'b1;
                        entry_count_next = entry_count_reg + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || report.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_value_next  = (status_reg == STAT_OK) ? value_reg : '0;
                    out_count_next  = STORED_W'(entry_count_reg);
                    if (status_reg != STAT_OK)
                    begin
                        sticky_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> verif/decimal_int_parse_dedup_checker.sv
// checker for the decimal token parser: tracks token and table state, predicts and compares reports
module decimal_int_parse_dedup_checker import dip_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    dip_in_if    tok_mon,
    dip_out_if   rep_mon,
    output int   mismatch_count,
    output int   reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic [STORED_W-1:0]       stored;
    } token_report_t;

    logic [VALUE_W-1:0] mag;
    bit                 neg;
    bit                 at_start;
    bit                 digit_seen;
    bit                 syntax_bad;
    bit                 overflow;
    bit                 sticky;
    logic [VALUE_W-1:0] value_store [TABLE_DEPTH];
    int unsigned        fill;
    token_report_t      due_reports [$];
    int                 errors;

    function automatic void restart_token();
        mag        = '0;
        neg        = 1'b0;
        at_start   = 1'b1;
        digit_seen = 1'b0;
        syntax_bad = 1'b0;
        overflow   = 1'b0;
    endfunction

    function automatic void take_char(logic [CHAR_W-1:0] ch);
        logic [63:0] grown;
        if (at_start && (ch == CHAR_PLUS || ch == CHAR_MINUS))
        begin
            neg = (ch == CHAR_MINUS);
        end
        else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            grown = 64'(mag) * 64'd10 + 64'(ch - CHAR_ZERO);
            digit_seen = 1'b1;
            if (grown > 64'(MAG_LIMIT))
            begin
                overflow = 1'b1;
                mag      = MAG_LIMIT;
            end
            else
            begin
                mag = grown[VALUE_W-1:0];
            end
        end
        else
        begin
            syntax_bad = 1'b1;
        end
        at_start = 1'b0;
    endfunction

    function automatic bit value_stored(logic [VALUE_W-1:0] v);
        for (int k = 0; k < int'(fill); k++)
        begin
            if (value_store[k] == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic token_report_t close_token();
        token_report_t      r;
        logic [VALUE_W-1:0] v;
        v       = neg ? -mag : mag;
        r.value = '0;
        if (sticky)
            r.status = STAT_REJECTED;
        else if (syntax_bad || !digit_seen)
            r.status = STAT_SYNTAX;
        else if (overflow || (!neg && mag == MAG_LIMIT))
            r.status = STAT_RANGE;
        else if (value_stored(v))
            r.status = STAT_DUP;
        else if (fill >= TABLE_DEPTH)
            r.status = STAT_FULL;
        else
        begin
            value_store[fill] = v;
            fill++;
            r.value  = v;
            r.status = STAT_OK;
        end
        if (r.status != STAT_OK)
            sticky = 1'b1;
        r.stored = STORED_W'(fill);
        restart_token();
        return r;
    endfunction

    always @(posedge clk)
    begin
        token_report_t seen;
        token_report_t want;
        if (!rst_n)
        begin
            restart_token();
            sticky = 1'b0;
            fill   = 0;
            due_reports.delete();
        end
        else
        begin
            if (tok_mon.valid && tok_mon.ready)
            begin
                case (tok_mon.command)
                    CMD_CLEAR:
                    begin
                        restart_token();
                        sticky = 1'b0;
                        fill   = 0;
                    end
                    CMD_CHAR: take_char(tok_mon.char_code);
                    CMD_END:  due_reports.push_back(close_token());
                    default: ;
                endcase
            end
            if (rep_mon.valid && rep_mon.ready)
            begin
                seen.status = rep_mon.status;
                seen.value  = rep_mon.parsed_value;
                seen.stored = rep_mon.stored_count;
                if (due_reports.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected report beat: status %0d value %0d stored %0d",
                                 seen.status, seen.value, seen.stored);
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (want.status !== seen.status || want.value !== seen.value
                        || want.stored !== seen.stored)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"report mismatch: expected status %0d value %0d stored %0d,",
                                      " got status %0d value %0d stored %0d"},
                                     want.status, want.value, want.stored,
                                     seen.status, seen.value, seen.stored);
                    end
                end
            end
        end
        mismatch_count <= errors;
        reports_due    <= due_reports.size();
    end

endmodule

>>> verif/decimal_int_parse_dedup_top_test.sv
// testbench top for the decimal token parser: clock, reset, token stimulus, report back-pressure, verdict
module decimal_int_parse_dedup_top_test;
    import dip_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam int               RANDOM_BEATS = 420;
    localparam int               HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   reports_due;
    int   beats_sent;
    int   edge_pick;
    bit   idle_en = 1'b1;
    bit   hold_go = 1'b0;
    string accepted_texts [$];
    string edge_texts [8] = '{"2147483647", "-2147483648", "2147483648", "-2147483649",
                              "4294967296", "99999999999999", "+0002147483647", "-0"};

    dip_in_if  tok_if ();
    dip_out_if rep_if ();

    decimal_int_parse_dedup_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (tok_if),
        .report (rep_if)
    );

    decimal_int_parse_dedup_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .tok_mon        (tok_if),
        .rep_mon        (rep_if),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // report side: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rep_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rep_if.ready <= 1'b0;
            end
            else if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
                rep_if.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 99) < 35)
            begin
                rep_if.ready <= 1'b0;
            end
            else
            begin
                rep_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch);
        int gap;
        gap = (idle_en && $urandom_range(0, 99) < 35) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            tok_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tok_if.valid     <= 1'b1;
        tok_if.command   <= cmd;
        tok_if.char_code <= ch;
        @(posedge clk);
        while (!tok_if.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_beat(CMD_CHAR, txt[i]);
    endtask

    task automatic send_token(input string txt);
        send_text(txt);
        send_beat(CMD_END, CHAR_W'($urandom_range(0, 255)));
    endtask

    task automatic clear_table();
        send_beat(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)));
        accepted_texts.delete();
    endtask

    task automatic drain_reports();
        tok_if.valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
    endtask

    task automatic send_random_token();
        int    roll;
        int    cut;
        string sign_txt;
        string lead_txt;
        string digit_txt;
        roll     = $urandom_range(0, 99);
        sign_txt = "";
        lead_txt = "";
        case ($urandom_range(0, 2))
            1: sign_txt = "+";
            2: sign_txt = "-";
            default: ;
        endcase
        if ($urandom_range(0, 1))
            digit_txt = $sformatf("%0d", $urandom_range(0, 999));
        else
            digit_txt = $sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF));
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 12)) lead_txt = {lead_txt, "0"};
        if (roll < 60)
        begin
            send_token({sign_txt, lead_txt, digit_txt});
            accepted_texts.push_back({sign_txt, digit_txt});
            if (accepted_texts.size() > 32)
                void'(accepted_texts.pop_front());
        end
        else if (roll < 72)
        begin
            if (accepted_texts.size() > 0)
                send_token(accepted_texts[$urandom_range(0, accepted_texts.size() - 1)]);
            else
                send_token("0");
        end
        else if (roll < 82)
        begin
            send_token(edge_texts[edge_pick % 8]);
            edge_pick++;
        end
        else if (roll < 94)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    cut = $urandom_range(0, digit_txt.len());
                    send_text({sign_txt, digit_txt.substr(0, cut - 1)});
                    send_beat(CMD_CHAR, CHAR_W'($urandom_range(0, 255)));
                    send_text(digit_txt.substr(cut, digit_txt.len() - 1));
                    send_beat(CMD_END, CHAR_W'($urandom_range(0, 255)));
                end
                1: send_token($urandom_range(0, 1) ? "+" : "-");
                2: send_token("");
                3: send_token({digit_txt, ($urandom_range(0, 1) ? "+" : "-"), "1"});
                default: send_token({($urandom_range(0, 1) ? "+" : "-"), "-", digit_txt});
            endcase
        end
        else
        begin
            send_beat(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)));
            send_token(digit_txt);
        end
    endtask

    initial
    begin
        int  done;
        int  rnd_start;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        rst_n            <= 1'b0;
        tok_if.valid     <= 1'b0;
        tok_if.command   <= CMD_CLEAR;
        tok_if.char_code <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: negative zero, plus sign, ignored command, duplicate with leading
        // zeros, sticky rejection, empty token, lone sign, late sign, stray byte
        clear_table();
        send_token("-0");
        send_token("+7");
        send_beat(CMD_UNUSED, 8'hFF);
        send_token("007");
        send_token("9");
        clear_table();
        send_token("");
        clear_table();
        send_token("-");
        clear_table();
        send_token("1+");
        clear_table();
        send_beat(CMD_CHAR, 8'h00);
        send_token("9");
        clear_table();

        rnd_start = beats_sent;
        while (beats_sent - rnd_start < RANDOM_BEATS)
        begin
            done = beats_sent - rnd_start;
            if (!hold_done && done > 120)
            begin
                hold_go   = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && done > 320)
            begin
                drain_reports();
                pause_done = 1'b1;
            end
            idle_en = !(done >= 180 && done < 280);
            if ($urandom_range(0, 99) < 12)
                clear_table();
            send_random_token();
        end

        drain_reports();
        repeat (TABLE_DEPTH + 16) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> decimal_int_parse_dedup_top.f
hdl/dip_pkg.sv
hdl/dip_in_if.sv
hdl/dip_out_if.sv
hdl/decimal_int_parse_dedup_top.sv
verif/decimal_int_parse_dedup_checker.sv
verif/decimal_int_parse_dedup_top_test.sv
